FILE: sv/lrutc_pkg.sv
`default_nettype none
package lrutc_pkg;

	localparam int TAG_W   = 15;
	localparam int STAMP_W = 32;
	localparam int ACT_W   = 9;
	localparam int SLOT_W  = 8;

	localparam logic [ACT_W-1:0]   ACTIVE_RESET = 9'd256;
	localparam logic [STAMP_W-1:0] STAMP_MAX    = 32'hFFFF_FFFF;

	// one directory entry: occupied flag and glyph tag
	typedef struct packed {
		logic             vld;
		logic [TAG_W-1:0] tag;
	} tag_entry_t;

	// scan outcome flags from the tracker
	typedef struct packed {
		logic hit;
		logic empty;
	} scan_flags_t;

	// sequencer states, one-hot
	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_SCAN  = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

endpackage
`default_nettype wire

FILE: sv/lrutc_track.sv
`default_nettype none
module lrutc_track #(
	parameter int IDX_W = 8
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                init,
	input  wire                                chk,
	input  wire [IDX_W-1:0]                    chk_idx,
	input  wire lrutc_pkg::tag_entry_t         ent,
	input  wire [lrutc_pkg::STAMP_W-1:0]       ent_stamp,
	input  wire [lrutc_pkg::TAG_W-1:0]         gid,
	output lrutc_pkg::scan_flags_t             flags,
	output logic [IDX_W-1:0]                   sel_idx
);

	logic                          hit_q;
	logic                          empty_q;
	logic [IDX_W-1:0]              hit_idx_q;
	logic [IDX_W-1:0]              empty_idx_q;
	logic [IDX_W-1:0]              min_idx_q;
	logic [lrutc_pkg::STAMP_W-1:0] min_stamp_q;

	// running first-hit, first-empty and oldest-stamp search
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q   <= 1'b0;
			empty_q <= 1'b0;
		end else if (init) begin
			hit_q   <= 1'b0;
			empty_q <= 1'b0;
		end else if (chk) begin
			if (ent.vld && ent.tag == gid && !hit_q) begin
				hit_q <= 1'b1;
			end
			if (!ent.vld && !empty_q) begin
				empty_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (init) begin
			min_stamp_q <= lrutc_pkg::STAMP_MAX;
			min_idx_q   <= '0;
		end else if (chk) begin
			if (ent.vld && ent.tag == gid && !hit_q) begin
				hit_idx_q <= chk_idx;
			end
			if (!ent.vld && !empty_q) begin
				empty_idx_q <= chk_idx;
			end
			// strict less keeps the lowest index on a tie
			if (ent.vld && ent_stamp < min_stamp_q) begin
				min_stamp_q <= ent_stamp;
				min_idx_q   <= chk_idx;
			end
		end
	end

	// hit wins, then first empty slot, then least recently used
	always_comb begin
		flags.hit   = hit_q;
		flags.empty = empty_q;
		priority if (hit_q) begin
			sel_idx = hit_idx_q;
		end else if (empty_q) begin
			sel_idx = empty_idx_q;
		end else begin
			sel_idx = min_idx_q;
		end
	end

endmodule
`default_nettype wire

FILE: sv/lru_tag_cache_lookup.sv
`default_nettype none
// lookup: an accepted request scans the n active slots, then loads the result register
//   (n = active slots); no new request is taken until the result is loaded. The scan reads
//   one entry per cycle through a single read port and one shared tag/stamp compare unit
// reset: asynchronous, active low; afterwards a clearing pass empties the tag store one slot
//   at a time, during which no request is taken (config writes are taken)
module lru_tag_cache_lookup #(
	parameter int CACHE_SLOTS = 256
) (
	input  wire        clk,
	input  wire        arst_n,
	// config write: active_slots
	input  wire        cfg_valid,
	output logic       cfg_ready,
	input  wire [8:0]  cfg_data,
	// requests
	input  wire        s_axis_tvalid,
	output logic       s_axis_tready,
	input  wire [15:0] s_axis_tdata,   // [14:0] glyph_id, [15] zero
	// results
	output logic       m_axis_tvalid,
	input  wire        m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] slot
	output logic [0:0] m_axis_tuser    // [0] hit
);

	localparam int IDX_W = $clog2(CACHE_SLOTS);
	localparam int CNT_W = IDX_W + 1;

	lrutc_pkg::state_t                state_q;
	logic [lrutc_pkg::ACT_W-1:0]      active_q;
	logic [CNT_W-1:0]                 n_eff;
	logic [CNT_W-1:0]                 n_q;
	logic [CNT_W-1:0]                 iss_q;
	logic [IDX_W-1:0]                 clr_q;
	logic [lrutc_pkg::TAG_W-1:0]      gid_q;
	logic [lrutc_pkg::STAMP_W-1:0]    use_q;
	logic                             chk_s1;
	logic [IDX_W-1:0]                 chk_idx_s1;
	lrutc_pkg::tag_entry_t            tag_rd_s1;
	logic [lrutc_pkg::STAMP_W-1:0]    stamp_rd_s1;
	lrutc_pkg::tag_entry_t            tag_mem [CACHE_SLOTS];
	logic [lrutc_pkg::STAMP_W-1:0]    stamp_mem [CACHE_SLOTS];
	logic                             accept;
	logic                             out_load;
	logic                             out_vld_q;
	logic                             hit_q;
	logic [lrutc_pkg::SLOT_W-1:0]     slot_q;
	lrutc_pkg::scan_flags_t           trk_flags;
	logic [IDX_W-1:0]                 sel_idx;
	logic                             tag_we;
	logic [IDX_W-1:0]                 tag_waddr;
	lrutc_pkg::tag_entry_t            tag_wdata;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == lrutc_pkg::ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign out_load      = (state_q == lrutc_pkg::ST_DONE) && (!out_vld_q || m_axis_tready);

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= lrutc_pkg::ACTIVE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			active_q <= cfg_data;
		end
	end

	// clamp active slot count to 1..CACHE_SLOTS
	always_comb begin
		priority if (active_q == '0) begin
			n_eff = CNT_W'(1);
		end else if (32'(active_q) > CACHE_SLOTS) begin
			n_eff = CNT_W'(CACHE_SLOTS);
		end else begin
			n_eff = CNT_W'(active_q);
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lrutc_pkg::ST_CLEAR;
			clr_q   <= '0;
			iss_q   <= '0;
			chk_s1  <= 1'b0;
			use_q   <= '0;
		end else begin
			chk_s1 <= (state_q == lrutc_pkg::ST_SCAN) && (iss_q < n_q);
			unique case (state_q)
				lrutc_pkg::ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == IDX_W'(CACHE_SLOTS - 1)) begin
						state_q <= lrutc_pkg::ST_IDLE;
					end
				end
				lrutc_pkg::ST_IDLE: begin
					if (accept) begin
						iss_q   <= '0;
						state_q <= lrutc_pkg::ST_SCAN;
					end
				end
				lrutc_pkg::ST_SCAN: begin
					if (iss_q < n_q) begin
						iss_q <= iss_q + 1'b1;
					end else if (!chk_s1) begin
						state_q <= lrutc_pkg::ST_DONE;
					end
				end
				lrutc_pkg::ST_DONE: begin
					if (out_load) begin
						use_q   <= use_q + 1'b1;
						state_q <= lrutc_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= lrutc_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (accept) begin
			gid_q <= s_axis_tdata[lrutc_pkg::TAG_W-1:0];
			n_q   <= n_eff;
		end
		chk_idx_s1 <= iss_q[IDX_W-1:0];
	end

	// tag store write: clearing pass or allocation on a miss
	always_comb begin
		tag_we    = 1'b0;
		tag_waddr = sel_idx;
		tag_wdata = '{vld: 1'b1, tag: gid_q};
		if (state_q == lrutc_pkg::ST_CLEAR) begin
			tag_we    = 1'b1;
			tag_waddr = clr_q;
			tag_wdata = '0;
		end else if (out_load && !trk_flags.hit) begin
			tag_we = 1'b1;
		end
	end

	// tag store
	always_ff @(posedge clk) begin
		if (tag_we) begin
			tag_mem[tag_waddr] <= tag_wdata;
		end
		tag_rd_s1 <= tag_mem[iss_q[IDX_W-1:0]];
	end

	// stamp store
	always_ff @(posedge clk) begin
		if (out_load) begin
			stamp_mem[sel_idx] <= use_q + 1'b1;
		end
		stamp_rd_s1 <= stamp_mem[iss_q[IDX_W-1:0]];
	end

	// shared compare unit
	lrutc_track #(
		.IDX_W(IDX_W)
	) u_track (
		.clk      (clk),
		.arst_n   (arst_n),
		.init     (accept),
		.chk      (chk_s1),
		.chk_idx  (chk_idx_s1),
		.ent      (tag_rd_s1),
		.ent_stamp(stamp_rd_s1),
		.gid      (gid_q),
		.flags    (trk_flags),
		.sel_idx  (sel_idx)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			hit_q  <= trk_flags.hit;
			slot_q <= lrutc_pkg::SLOT_W'(sel_idx);
		end
	end

	assign m_axis_tvalid   = out_vld_q;
	assign m_axis_tdata    = slot_q;
	assign m_axis_tuser[0] = hit_q;

	// checks
	a_chk_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		chk_s1 |-> CNT_W'(chk_idx_s1) < n_q)
		else $error("scan compares a slot outside the active range");

	a_victim_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> CNT_W'(sel_idx) < n_q)
		else $error("selected slot outside the active range");

	a_stamp_advance: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (use_q == $past(use_q) + 1'b1) && m_axis_tvalid)
		else $error("use counter or result register out of step with completion");

endmodule
`default_nettype wire
